// ===== rtl/b64e_pkg.sv =====
// shared types, constants and the character map of the base64 stream encoder
`timescale 1ns / 1ps

package b64e_pkg;

    // characters per line when line breaks are on
    localparam int LINE_LENGTH = 76;
    // line counter width, enough to hold LINE_LENGTH itself
    localparam int LP_W = $clog2(LINE_LENGTH + 1);

    localparam logic [7:0] CHAR_PAD = 8'h3D;
    localparam logic [7:0] CHAR_NL  = 8'h0A;

    // register map
    localparam logic REG_ALPHABET    = 1'b0;
    localparam logic REG_LINE_BREAKS = 1'b1;

    // one group of up to three bytes, zero filled, handed from front to back
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] count;
        logic       last;
    } t_group;

    // sextet to ascii, standard or url-safe alphabet
    function automatic logic [7:0] b64e_char(input logic [5:0] v, input logic url);
        logic [7:0] c;
        begin
            if (v < 6'd26) begin
                c = 8'h41 + {2'b00, v};
            end else if (v < 6'd52) begin
                c = 8'h61 + {2'b00, v} - 8'd26;
            end else if (v < 6'd62) begin
                c = 8'h30 + {2'b00, v} - 8'd52;
            end else if (v == 6'd62) begin
                c = url ? 8'h2D : 8'h2B;
            end else begin
                c = url ? 8'h5F : 8'h2F;
            end
            return c;
        end
    endfunction

endpackage

// ===== rtl/b64e_front.sv =====
// front part: packs bytes into groups of three, pushes each full or last group
`timescale 1ns / 1ps

module b64e_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    input  logic              i_q_full,
    output logic              o_push,
    output b64e_pkg::t_group  o_group
);
    import b64e_pkg::*;

    logic [15:0] r_held;
    logic [1:0]  r_fill;
    logic [15:0] n_held;
    logic [1:0]  n_fill;
    logic        w_accept;
    logic [1:0]  w_count;

    assign o_in_ready = !i_q_full;
    assign w_accept   = i_in_valid && !i_q_full;
    // fill never reaches three, a group is pushed at two held bytes
    assign w_count    = r_fill + 2'd1;
    assign o_push     = w_accept && (r_fill == 2'd2 || i_last_byte);

    // assemble the zero-filled group from held bytes and the new byte
    always_comb begin
        o_group.count = w_count;
        o_group.last  = i_last_byte;
        case (r_fill)
            2'd0: begin
                o_group.b0 = i_data_byte;
                o_group.b1 = 8'h00;
                o_group.b2 = 8'h00;
            end
            2'd1: begin
                o_group.b0 = r_held[15:8];
                o_group.b1 = i_data_byte;
                o_group.b2 = 8'h00;
            end
            default: begin
                o_group.b0 = r_held[15:8];
                o_group.b1 = r_held[7:0];
                o_group.b2 = i_data_byte;
            end
        endcase
    end

    // hold bytes of an incomplete group
    always_comb begin
        n_held = r_held;
        n_fill = r_fill;
        if (o_push) begin
            n_held = 16'h0000;
            n_fill = 2'd0;
        end else if (w_accept) begin
            if (r_fill == 2'd0) begin
                n_held = {i_data_byte, 8'h00};
            end else begin
                n_held = {r_held[15:8], i_data_byte};
            end
            n_fill = w_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 16'h0000;
            r_fill <= 2'd0;
        end else begin
            r_held <= n_held;
            r_fill <= n_fill;
        end
    end

endmodule

// ===== rtl/b64e_queue.sv =====
// two-entry group queue between front and back
`timescale 1ns / 1ps

module b64e_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  b64e_pkg::t_group  i_group,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output b64e_pkg::t_group  o_group
);
    import b64e_pkg::*;

    t_group     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_group = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_group;
        end
    end

    // pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/b64e_back.sv =====
// back part: one character a cycle unless stalled, with line breaks and padding
`timescale 1ns / 1ps

module b64e_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_alphabet_select,
    input  logic              i_line_breaks_enable,
    input  logic              i_q_valid,
    input  b64e_pkg::t_group  i_group,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_out_char,
    output logic              o_end_of_run,
    output logic              o_end_of_message
);
    import b64e_pkg::*;

    logic [1:0]      r_pos;
    logic [LP_W-1:0] r_line_pos;
    logic            r_out_valid;
    logic [7:0]      r_out_char;
    logic            r_eor;
    logic            r_eom;

    logic [1:0]      n_pos;
    logic [LP_W-1:0] n_line_pos;
    logic            w_advance;
    logic            w_line_full;
    logic            w_need_nl;
    logic [5:0]      w_sextet;
    logic [7:0]      w_char;
    logic [LP_W-1:0] w_base;

    assign w_advance   = i_q_valid && (!r_out_valid || i_out_ready);
    assign w_line_full = (r_line_pos >= LP_W'(LINE_LENGTH));
    assign w_need_nl   = w_line_full && i_line_breaks_enable;
    assign w_base      = w_line_full ? '0 : r_line_pos;

    // pick the sextet for the current character
    always_comb begin
        case (r_pos)
            2'd0:    w_sextet = i_group.b0[7:2];
            2'd1:    w_sextet = {i_group.b0[1:0], i_group.b1[7:4]};
            2'd2:    w_sextet = {i_group.b1[3:0], i_group.b2[7:6]};
            default: w_sextet = i_group.b2[5:0];
        endcase
    end

    assign w_char = (r_pos <= i_group.count) ? b64e_char(w_sextet, i_alphabet_select)
                                             : CHAR_PAD;

    // sequencing over the four characters and the line counter
    always_comb begin
        n_pos      = r_pos;
        n_line_pos = r_line_pos;
        o_pop      = 1'b0;
        if (w_advance) begin
            if (w_need_nl) begin
                n_line_pos = '0;
            end else begin
                n_line_pos = w_base + LP_W'(1);
                if (r_pos == 2'd3) begin
                    n_pos = 2'd0;
                    o_pop = 1'b1;
                    if (i_group.last) begin
                        n_line_pos = '0;
                    end
                end else begin
                    n_pos = r_pos + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= 2'd0;
            r_line_pos <= '0;
        end else begin
            r_pos      <= n_pos;
            r_line_pos <= n_line_pos;
        end
    end

    // output register, holds while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            if (w_need_nl) begin
                r_out_char <= CHAR_NL;
                r_eor      <= 1'b0;
                r_eom      <= 1'b0;
            end else begin
                r_out_char <= w_char;
                r_eor      <= (r_pos == 2'd3);
                r_eom      <= (r_pos == 2'd3) && i_group.last;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_char       = r_out_char;
    assign o_end_of_run     = r_eor;
    assign o_end_of_message = r_eom;

endmodule

// ===== rtl/base64_stream_encoder_unit.sv =====
// top level of the base64 stream encoder: config registers, front, queue and back
`timescale 1ns / 1ps

// Base64 stream encoder (standard or url-safe alphabet, optional line breaks).
// Input channel: one message byte per item on i_data_byte, i_last_byte marks the
// final byte. Output channel: one ascii character per item on o_out_char;
// o_end_of_run flags the last character caused by an input byte, o_end_of_message
// the final character of the encoding. Padding '=' fills the last group.
// Config over the apb port: address 0 alphabet select, address 4 line breaks
// enable (newline after every LINE_LENGTH characters, never after the last).
// Write config only while the block is idle.
// A byte that completes a group (or is last) pushes the group into the queue; the
// back part then registers its characters one by one in the output register, for
// the receiver to take: four characters plus any newline.
// The back part emits one character per cycle while a group is queued and the
// receiver takes them; a byte can be taken every cycle while the two-entry group
// queue has room.
// Reset clears the held bytes, the queue, the line counter, the output valid
// and both config registers. A stalled receiver holds the output register; the
// back part stops, the queue fills and then o_in_ready drops.

module base64_stream_encoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_char,
    output logic        o_end_of_run,
    output logic        o_end_of_message,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import b64e_pkg::*;

    logic   r_alphabet_select;
    logic   r_line_breaks_enable;
    logic   w_cfg_wr;
    logic   w_push;
    logic   w_pop;
    logic   w_q_full;
    logic   w_q_valid;
    t_group w_front_group;
    t_group w_back_group;

    // config registers
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alphabet_select    <= 1'b0;
            r_line_breaks_enable <= 1'b0;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_ALPHABET:    r_alphabet_select    <= pwdata[0];
                REG_LINE_BREAKS: r_line_breaks_enable <= pwdata[0];
                default:         r_alphabet_select    <= r_alphabet_select;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (paddr[2])
            REG_ALPHABET:    prdata = {31'd0, r_alphabet_select};
            REG_LINE_BREAKS: prdata = {31'd0, r_line_breaks_enable};
            default:         prdata = 32'd0;
        endcase
    end

    b64e_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_group     (w_front_group)
    );

    b64e_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_group (w_front_group),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_group (w_back_group)
    );

    b64e_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_alphabet_select    (r_alphabet_select),
        .i_line_breaks_enable (r_line_breaks_enable),
        .i_q_valid            (w_q_valid),
        .i_group              (w_back_group),
        .o_pop                (w_pop),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_out_char           (o_out_char),
        .o_end_of_run         (o_end_of_run),
        .o_end_of_message     (o_end_of_message)
    );

endmodule

// ===== rtl/b64e_checker.sv =====
// port-level checks of the base64 stream encoder and their bind
`timescale 1ns / 1ps

module b64e_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_char,
    input logic       o_end_of_run,
    input logic       o_end_of_message
);
    import b64e_pkg::*;

    // the output is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a stalled character holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_char)))
        else $error("stalled character changed");

    // end of message only on the end of a run
    a_eom_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_end_of_message) |-> o_end_of_run)
        else $error("end of message without end of run");

    // a newline never closes a run
    a_nl_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_char == CHAR_NL) |-> !o_end_of_run)
        else $error("newline flagged as end of run");

endmodule

bind base64_stream_encoder_unit b64e_checker u_b64e_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_out_char       (o_out_char),
    .o_end_of_run     (o_end_of_run),
    .o_end_of_message (o_end_of_message)
);

// ===== bench/b64e_tb_pkg.sv =====
// scoreboard class of the base64 stream encoder bench: encoding predictor and character queue
`timescale 1ns / 1ps

package b64e_tb_pkg;

    import b64e_pkg::*;

    localparam string STD_MAP = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam string URL_MAP = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

    // one expected output character with its flags
    typedef struct {
        logic [7:0] ch;
        logic       run_end;
        logic       msg_end;
    } t_exp_char;

    class b64e_char_scoreboard;
        // config mirror
        bit url_alpha;
        bit breaks_on;
        // encoder state mirror
        logic [15:0] held;
        int          fill;
        int          line_pos;
        // characters still owed by the block
        t_exp_char   pending_chars[$];
        // statistics
        int errors;
        int bytes_seen;
        int messages;
        int chars_checked;
        int newlines_checked;

        function new();
            url_alpha = 0;
            breaks_on = 0;
            held = '0;
            fill = 0;
            line_pos = 0;
            errors = 0;
            bytes_seen = 0;
            messages = 0;
            chars_checked = 0;
            newlines_checked = 0;
        endfunction

        function void set_alphabet(logic v);
            url_alpha = v;
        endfunction

        function void set_breaks(logic v);
            breaks_on = v;
        endfunction

        function int pending();
            return pending_chars.size();
        endfunction

        function logic [7:0] sextet_to_ascii(logic [5:0] v);
            return url_alpha ? URL_MAP[v] : STD_MAP[v];
        endfunction

        // accepted input item: work out the characters it releases
        function void encode_byte(logic [7:0] b, logic last);
            int          count;
            logic [7:0]  b0;
            logic [7:0]  b1;
            logic [7:0]  b2;
            logic [5:0]  sx [4];
            logic [7:0]  ch;
            logic [7:0]  burst [$];
            t_exp_char   e;

            bytes_seen++;
            if (fill == 0) begin
                held = {b, 8'h00};
            end else if (fill == 1) begin
                held[7:0] = b;
            end
            count = fill + 1;
            // partial group, nothing out yet
            if (count < 3 && !last) begin
                fill = count;
                return;
            end

            b0 = (count == 1) ? b : held[15:8];
            b1 = (count >= 2) ? held[7:0] : 8'h00;
            b2 = (count >= 3) ? b : 8'h00;
            sx[0] = b0[7:2];
            sx[1] = {b0[1:0], b1[7:4]};
            sx[2] = {b1[3:0], b2[7:6]};
            sx[3] = b2[5:0];

            // four characters, padding past the real bytes, newline on full line
            for (int i = 0; i < 4; i++) begin
                ch = (i <= count) ? sextet_to_ascii(sx[i]) : CHAR_PAD;
                if (line_pos >= LINE_LENGTH) begin
                    if (breaks_on) begin
                        burst.push_back(CHAR_NL);
                    end
                    line_pos = 0;
                end
                burst.push_back(ch);
                line_pos = (line_pos + 1) & 8'h7F;
            end

            foreach (burst[k]) begin
                e.ch      = burst[k];
                e.run_end = (k == burst.size() - 1);
                e.msg_end = (k == burst.size() - 1) && last;
                pending_chars.push_back(e);
            end

            held = '0;
            fill = 0;
            if (last) begin
                line_pos = 0;
                messages++;
            end
        endfunction

        // accepted output item against the oldest expectation
        function void check_char(logic [7:0] ch, logic run_end, logic msg_end);
            t_exp_char e;

            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected char act=%h eor=%b eom=%b", $time, ch, run_end, msg_end);
                errors++;
                return;
            end
            e = pending_chars.pop_front();
            chars_checked++;
            if (e.ch == CHAR_NL) begin
                newlines_checked++;
            end
            if (ch !== e.ch) begin
                $display("%0t: char mismatch exp=%h act=%h", $time, e.ch, ch);
                errors++;
            end
            if (run_end !== e.run_end) begin
                $display("%0t: end_of_run mismatch exp=%b act=%b", $time, e.run_end, run_end);
                errors++;
            end
            if (msg_end !== e.msg_end) begin
                $display("%0t: end_of_message mismatch exp=%b act=%b", $time, e.msg_end, msg_end);
                errors++;
            end
        endfunction

        // whatever is still owed at the end counts against the run
        function void close_out();
            if (pending_chars.size() != 0) begin
                $display("%0t: %0d chars never arrived, next exp=%h act=none",
                         $time, pending_chars.size(), pending_chars[0].ch);
                errors += pending_chars.size();
            end
        endfunction
    endclass

endpackage

// ===== bench/tb_base64_stream_encoder_unit.sv =====
// top of the base64 stream encoder bench: clock, reset, stimulus, receiver and apb writes
`timescale 1ns / 1ps

module tb_base64_stream_encoder_unit;

    import b64e_pkg::*;
    import b64e_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int SETTLE_TICKS = 8;
    localparam int LONG_HOLD    = 90;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_out_char;
    logic        o_end_of_run;
    logic        o_end_of_message;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    b64e_char_scoreboard sb;

    int  cycle_count;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  msg_left;
    bit  rst_done;
    bit  hold_req;
    int  holds_done;

    base64_stream_encoder_unit i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_char       (o_out_char),
        .o_end_of_run     (o_end_of_run),
        .o_end_of_message (o_end_of_message),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // 8 ns clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // cycle watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off on request, checks each char item
    initial begin
        int hold_left;
        hold_left = 0;
        wait (rst_done);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                sb.check_char(o_out_char, o_end_of_run, o_end_of_message);
            end
            if (hold_req && hold_left == 0) begin
                hold_left = LONG_HOLD;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                if (hold_left == 0) begin
                    holds_done++;
                end
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // one input item, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        sb.encode_byte(b, last);
    endtask

    // random bytes, messages mostly short with some long enough to wrap lines
    task automatic send_random(input int n);
        logic [7:0] b;
        for (int i = 0; i < n; i++) begin
            if (msg_left == 0) begin
                msg_left = ($urandom_range(0, 99) < 65) ? $urandom_range(1, 9)
                                                         : $urandom_range(30, 130);
            end
            b = $urandom_range(0, 255);
            send_byte(b, msg_left == 1);
            msg_left--;
        end
        i_in_valid <= 1'b0;
    endtask

    // wait for every owed char, then for the block to settle
    task automatic drain();
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    // apb write: setup then access cycle, then the bus returns to idle
    task automatic cfg_write(input logic idx, input logic val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {31'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_ALPHABET) begin
            sb.set_alphabet(val);
        end else begin
            sb.set_breaks(val);
        end
    endtask

    // new register values plus idling mix for the next stretch
    task automatic start_phase(input logic url, input logic brk, input int s_pct,
                               input int r_pct);
        drain();
        cfg_write(REG_ALPHABET, url);
        cfg_write(REG_LINE_BREAKS, brk);
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
    endtask

    initial begin
        logic [7:0] directed_bytes [$];
        logic       directed_last  [$];

        sb = new();
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_data_byte    = 8'h00;
        i_last_byte    = 1'b0;
        i_out_ready    = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        msg_left       = 0;
        rst_done       = 0;
        hold_req       = 0;
        holds_done     = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rst_done = 1;
        @(posedge i_clk);

        // directed: one, two and three byte messages at the byte extremes,
        // sextets 62 and 63, then a full group followed by each partial group
        directed_bytes = {8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00,
                          8'hFF, 8'hFF, 8'hFF, 8'hFB, 8'hFF, 8'hBF,
                          8'h4D, 8'h61, 8'h6E, 8'h20,
                          8'h01, 8'h02, 8'h03, 8'h04, 8'h05};
        directed_last  = {1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1,
                          1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1,
                          1'b0, 1'b0, 1'b0, 1'b1,
                          1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
        foreach (directed_bytes[k]) begin
            send_byte(directed_bytes[k], directed_last[k]);
        end
        i_in_valid <= 1'b0;

        // same sextet extremes through the url-safe alphabet
        start_phase(1'b1, 1'b0, 0, 0);
        send_byte(8'hFB, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hBF, 1'b1);

        // random stretches; messages run on across register changes
        send_random(38);
        start_phase(1'b0, 1'b1, 71, 0);
        send_random(40);
        start_phase(1'b1, 1'b1, 0, 71);
        send_random(40);
        start_phase(1'b0, 1'b0, 17, 17);
        send_random(40);

        // long receiver hold-off while bytes keep coming, block backs up
        start_phase(1'b1, 1'b1, 0, 0);
        hold_req = 1;
        send_random(40);
        start_phase(1'b0, 1'b1, 17, 17);
        send_random(40);
        start_phase(1'b1, 1'b0, 0, 71);
        send_random(40);
        start_phase(1'b0, 1'b1, 71, 0);
        send_random(40);

        drain();
        repeat (10) @(posedge i_clk);
        sb.close_out();

        $display("covered %0d bytes in %0d complete messages, %0d hold-off(s)",
                 sb.bytes_seen, sb.messages, holds_done);
        $display("checked %0d output chars, %0d of them line breaks",
                 sb.chars_checked, sb.newlines_checked);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
